### sv/midi_track_event_parser_macros.svh
// Assertion macros shared by the track event parser RTL.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define MTEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MTEP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### sv/mtep_pkg.sv
// Types and constants of the MIDI track event parser.
package mtep_pkg;

  localparam int unsigned FIELD_W = 28;

  // Result kind codes
  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_META    = 2'd1;
  localparam logic [1:0] KIND_SYSEX   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Special status bytes
  localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
  localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] STATUS_META     = 8'hFF;
  localparam logic [7:0] NIBBLE_HI_MASK  = 8'hF0;
  localparam logic [7:0] NIBBLE_LO_MASK  = 8'h0F;
  localparam logic [3:0] NIB_PROG_CHANGE = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRESS  = 4'hD;
  localparam logic [2:0] MAX_COUNT_BYTES = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_DATA1   = 6'b000010,
    PH_DATA2   = 6'b000100,
    PH_METATYP = 6'b001000,
    PH_VARLEN  = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_e;

  // One result item
  typedef struct packed {
    logic [FIELD_W-1:0] event_delta;
    logic [FIELD_W-1:0] payload_len;
    logic [FIELD_W-1:0] byte_index;
    logic [7:0]         second_data;
    logic [7:0]         first_data;
    logic [3:0]         channel;
    logic [7:0]         event_type;
    logic               last;
    logic               empty_res;
    logic [1:0]         kind;
  } res_t;

endpackage

### sv/midi_track_event_parser.sv
// Standard MIDI file track event body parser with running status.
// A result is registered into the main output entry, or into the skid entry while the main entry is held.
// Throughput: one byte per cycle while the skid entry is empty; input stalls while it holds a result.
// A two-entry output register (main plus skid) keeps input accepting while a result waits.
// Reset (rst_ni low, asynchronous) clears running status, phase and both output entries.
`include "midi_track_event_parser_macros.svh"

module midi_track_event_parser
  import mtep_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 28
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [35:8] delta_time, [39:36] zero
  input  logic [39:0]  s_axis_tdata,
  // [0] event_start
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [7:0] event_type, [11:8] channel, [19:12] first_data, [27:20] second_data,
  // [55:28] byte_index, [83:56] payload_len, [111:84] event_delta
  output logic [111:0] m_axis_tdata,
  // [1:0] kind, [2] empty_res
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned LEN_W = (LENGTH_BITS < FIELD_W) ? LENGTH_BITS : FIELD_W;

  // Parser state
  phase_e             phase_q, phase_d;
  logic [7:0]         running_status_q, running_status_d;
  logic [7:0]         held_first_q, held_first_d;
  logic [7:0]         held_type_q, held_type_d;
  logic [LEN_W-1:0]   len_accum_q, len_accum_d;
  logic [2:0]         len_bytes_q, len_bytes_d;
  logic [LEN_W-1:0]   remaining_q, remaining_d;
  logic [LEN_W-1:0]   pay_index_q, pay_index_d;
  logic [FIELD_W-1:0] held_delta_q, held_delta_d;

  // Output entries
  logic out_valid_q, skid_valid_q;
  res_t out_q, skid_q;

  logic               in_accept;
  logic               out_pop;
  logic               res_valid;
  res_t               res;
  logic [7:0]         in_byte;
  logic               in_start;
  logic [FIELD_W-1:0] in_delta;
  logic [LEN_W+6:0]   acc;
  logic               hold_sysex;
  logic               pay_fin;

  assign in_byte  = s_axis_tdata[7:0];
  assign in_delta = s_axis_tdata[35:8];
  assign in_start = s_axis_tuser;

  assign s_axis_tready = !skid_valid_q;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_pop       = out_valid_q && m_axis_tready;

  assign acc        = {len_accum_q, in_byte[6:0]};
  assign hold_sysex = (held_type_q == STATUS_SYSEX) || (held_type_q == STATUS_SYSEX_ESC);
  assign pay_fin    = (remaining_q <= LEN_W'(1));

  // Error result for a given type byte
  function automatic res_t error_res(input logic [7:0] etype);
    res_t r;
    r            = '0;
    r.kind       = KIND_ERROR;
    r.event_type = etype;
    r.last       = 1'b1;
    return r;
  endfunction

  // Channel message result from the running status
  function automatic res_t channel_res(input logic [7:0] status, input logic [7:0] d1,
                                       input logic [7:0] d2);
    res_t r;
    r             = '0;
    r.kind        = KIND_CHANNEL;
    r.event_type  = {4'h0, status[7:4]};
    r.channel     = status[3:0];
    r.first_data  = d1;
    r.second_data = d2;
    r.last        = 1'b1;
    return r;
  endfunction

  // One- or two-data-byte check on a status
  function automatic logic one_data(input logic [7:0] status);
    logic [3:0] nib;
    nib = status[7:4];
    return (nib == NIB_PROG_CHANGE) || (nib == NIB_CHAN_PRESS);
  endfunction

  // Next state and result of the accepted byte
  always_comb begin
    phase_d          = phase_q;
    running_status_d = running_status_q;
    held_first_d     = held_first_q;
    held_type_d      = held_type_q;
    len_accum_d      = len_accum_q;
    len_bytes_d      = len_bytes_q;
    remaining_d      = remaining_q;
    pay_index_d      = pay_index_q;
    held_delta_d     = held_delta_q;
    res_valid        = 1'b0;
    res              = '0;

    if (in_start) begin
      held_delta_d = in_delta;
      phase_d      = PH_IDLE;
      if (!in_byte[7]) begin
        if (running_status_q == 8'h00) begin
          res_valid = 1'b1;
          res       = error_res(in_byte);
        end else begin
          held_first_d = in_byte;
          if (one_data(running_status_q)) begin
            res_valid = 1'b1;
            res       = channel_res(running_status_q, in_byte, 8'h00);
          end else begin
            phase_d = PH_DATA2;
          end
        end
      end else if ((in_byte & NIBBLE_HI_MASK) != NIBBLE_HI_MASK) begin
        running_status_d = in_byte;
        held_type_d      = in_byte;
        phase_d          = PH_DATA1;
      end else if (in_byte == STATUS_META) begin
        phase_d = PH_METATYP;
      end else if ((in_byte == STATUS_SYSEX) || (in_byte == STATUS_SYSEX_ESC)) begin
        held_type_d = in_byte;
        len_accum_d = '0;
        len_bytes_d = '0;
        phase_d     = PH_VARLEN;
      end else begin
        res_valid = 1'b1;
        res       = error_res(in_byte);
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_DATA1: begin
          held_first_d = in_byte;
          if (one_data(running_status_q)) begin
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res       = channel_res(running_status_q, in_byte, 8'h00);
          end else begin
            phase_d = PH_DATA2;
          end
        end
        PH_DATA2: begin
          phase_d   = PH_IDLE;
          res_valid = 1'b1;
          res       = channel_res(running_status_q, held_first_q, in_byte);
        end
        PH_METATYP: begin
          held_type_d = in_byte;
          len_accum_d = '0;
          len_bytes_d = '0;
          phase_d     = PH_VARLEN;
        end
        PH_VARLEN: begin
          len_bytes_d = len_bytes_q + 3'd1;
          if (|acc[LEN_W+6:LEN_W]) begin
            // count too wide for the length register
            phase_d   = PH_IDLE;
            res_valid = 1'b1;
            res       = error_res(held_type_q);
          end else begin
            len_accum_d = acc[LEN_W-1:0];
            if (in_byte[7]) begin
              if (len_bytes_d >= MAX_COUNT_BYTES) begin
                phase_d   = PH_IDLE;
                res_valid = 1'b1;
                res       = error_res(held_type_q);
              end
            end else if (acc[LEN_W-1:0] == '0) begin
              // empty payload: one result
              phase_d        = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = hold_sysex ? KIND_SYSEX : KIND_META;
              res.event_type = held_type_q;
              res.empty_res  = 1'b1;
              res.last       = 1'b1;
            end else begin
              remaining_d = acc[LEN_W-1:0];
              pay_index_d = '0;
              phase_d     = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          remaining_d     = pay_fin ? '0 : remaining_q - LEN_W'(1);
          pay_index_d     = pay_index_q + LEN_W'(1);
          if (pay_fin) begin
            phase_d = PH_IDLE;
          end
          res_valid       = 1'b1;
          res.kind        = hold_sysex ? KIND_SYSEX : KIND_META;
          res.event_type  = held_type_q;
          res.first_data  = in_byte;
          res.byte_index  = FIELD_W'(pay_index_q);
          res.payload_len = FIELD_W'(len_accum_q);
          res.last        = pay_fin;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    res.event_delta = held_delta_d;
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q          <= PH_IDLE;
      running_status_q <= '0;
      held_first_q     <= '0;
      held_type_q      <= '0;
      len_accum_q      <= '0;
      len_bytes_q      <= '0;
      remaining_q      <= '0;
      pay_index_q      <= '0;
      held_delta_q     <= '0;
    end else if (in_accept) begin
      phase_q          <= phase_d;
      running_status_q <= running_status_d;
      held_first_q     <= held_first_d;
      held_type_q      <= held_type_d;
      len_accum_q      <= len_accum_d;
      len_bytes_q      <= len_bytes_d;
      remaining_q      <= remaining_d;
      pay_index_q      <= pay_index_d;
      held_delta_q     <= held_delta_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_accept && res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (in_accept && res_valid) begin
      if (!out_valid_q || out_pop) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.event_delta, out_q.payload_len, out_q.byte_index,
                          out_q.second_data, out_q.first_data, out_q.channel,
                          out_q.event_type};
  assign m_axis_tuser  = {out_q.empty_res, out_q.kind};
  assign m_axis_tlast  = out_q.last;

  // Checks
  `MTEP_ASSERT_ALWAYS(a_skid_needs_out, !skid_valid_q || out_valid_q, "skid entry without main entry")
  `MTEP_ASSERT(a_data2_closes, in_accept && !in_start && (phase_q == PH_DATA2) |=> phase_q == PH_IDLE, "second data byte left event open")
  `MTEP_ASSERT(a_index_in_range, out_valid_q && (out_q.kind == KIND_META || out_q.kind == KIND_SYSEX) && !out_q.empty_res |-> out_q.byte_index < out_q.payload_len, "payload index beyond count")
  `MTEP_ASSERT(a_last_at_end, out_valid_q && out_q.last && (out_q.kind == KIND_META || out_q.kind == KIND_SYSEX) && !out_q.empty_res |-> out_q.byte_index + 28'd1 == out_q.payload_len, "last flag not on final payload byte")

endmodule
